>>> rtl/lnat_pkg.sv
// Package for the ln atanh-series unit: fixed-point sizes, pipeline depths
// and the word types passed between pipeline stages. No dependencies.
package lnat_pkg;

    localparam int N_W           = 16;                 // argument width
    localparam int RES_W         = 30;                 // result width
    localparam int FRAC_BITS     = 28;                 // fraction bits of c, z, s
    localparam int NUM_TERMS     = 7;                  // atanh series terms
    localparam int DIV_STEP_BITS = 4;                  // quotient bits per divider stage
    localparam int DIV_STAGES    = (FRAC_BITS + DIV_STEP_BITS - 1) / DIV_STEP_BITS;
    localparam int QUO_W         = DIV_STAGES * DIV_STEP_BITS;
    localparam int REM_W         = N_W + 1;            // remainder and divisor width
    localparam int S_W           = FRAC_BITS + 2;      // Horner sum width (value below 4)
    localparam int PIPE_STAGES   = DIV_STAGES + NUM_TERMS + 1;

    localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

    // Innermost Horner coefficient, 1/(2K-1) in fixed point
    localparam logic [S_W-1:0] S_INIT = S_W'((64'd1 << FRAC_BITS) / (2 * NUM_TERMS - 1));

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic             invalid;
    } t_div_word;

    typedef struct packed {
        logic [FRAC_BITS-1:0] c;
        logic [FRAC_BITS-1:0] z;
        logic [S_W-1:0]       s;
        logic                 invalid;
    } t_hor_word;

endpackage

>>> rtl/lnat_div_stage.sv
// One stage of the restoring divider that forms c = (n-1)/(n+1).
// Depends on lnat_pkg for widths and the divider word type.
module lnat_div_stage
    import lnat_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_load,
    input  t_div_word i_word,
    output t_div_word o_word
);

    t_div_word r_word;
    t_div_word n_word;

    always_comb begin
        logic [REM_W:0] v_sh;
        n_word = i_word;
        for (int j = 0; j < DIV_STEP_BITS; j++) begin
            v_sh = {n_word.rem, 1'b0};
            if (v_sh >= {1'b0, i_word.den}) begin
                n_word.rem = REM_W'(v_sh - {1'b0, i_word.den});
                n_word.quo = {n_word.quo[QUO_W-2:0], 1'b1};
            end else begin
                n_word.rem = v_sh[REM_W-1:0];
                n_word.quo = {n_word.quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

>>> rtl/lnat_horner_stage.sv
// One Horner step of the series: s' = 1/(2k-1) + (z*s) >> FRAC_BITS.
// Depends on lnat_pkg for widths and the Horner word type.
module lnat_horner_stage
    import lnat_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_load,
    input  logic [S_W-1:0] i_recip,
    input  t_hor_word      i_word,
    output t_hor_word      o_word
);

    logic [FRAC_BITS+S_W-1:0] w_prod;
    t_hor_word                r_word;
    t_hor_word                n_word;

    assign w_prod = i_word.z * i_word.s;

    always_comb begin
        n_word   = i_word;
        n_word.s = S_W'(i_recip + w_prod[FRAC_BITS+S_W-1:FRAC_BITS]);
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

>>> rtl/ln_atanh_series_unit.sv
// Natural log of a 16-bit integer as twice the truncated atanh series.
// Depth: PIPE_STAGES register stages (15 as built). Throughput: one word per
// cycle while the receiver does not stall, set by the pipelined divider
// (4 quotient bits a stage) and one multiplier per Horner stage. Reset
// clears only the stage valid bits.
// Depends on lnat_pkg, lnat_div_stage and lnat_horner_stage.
module ln_atanh_series_unit
    import lnat_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [N_W-1:0]   i_n_value,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [RES_W-1:0] o_log_result,
    output logic             o_invalid_arg
);

    localparam int Z_IDX   = DIV_STAGES;
    localparam int OUT_IDX = PIPE_STAGES - 1;
    localparam int R_W     = S_W + 1;
    localparam int CMP_W   = (R_W > RES_W) ? R_W : RES_W;

    // Stage valid bits and the ready chain. A stage takes a new word when it
    // is empty or its own word moves on, so bubbles close up behind a stall.
    logic [PIPE_STAGES-1:0] r_vld;
    logic [PIPE_STAGES-1:0] n_vld;
    logic [PIPE_STAGES:0]   w_rdy;

    always_comb begin
        w_rdy[PIPE_STAGES] = i_ready;
        for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_comb begin
        for (int k = 0; k < PIPE_STAGES; k++) begin
            if (w_rdy[k]) begin
                n_vld[k] = (k == 0) ? i_valid : r_vld[(k == 0) ? 0 : k - 1];
            end else begin
                n_vld[k] = r_vld[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[OUT_IDX];

    // Divider: remainder starts at n-1 (below n+1, so the quotient fits);
    // a zero argument starts from zero and is flagged.
    t_div_word w_div [DIV_STAGES+1];

    always_comb begin
        w_div[0].invalid = (i_n_value == '0);
        w_div[0].den     = REM_W'({1'b0, i_n_value} + REM_W'(1));
        w_div[0].rem     = w_div[0].invalid ? '0 : REM_W'(i_n_value - N_W'(1));
        w_div[0].quo     = '0;
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
        lnat_div_stage u_div (
            .i_clk  (i_clk),
            .i_load (w_rdy[g]),
            .i_word (w_div[g]),
            .o_word (w_div[g+1])
        );
    end

    // Square stage: drop the extra quotient bits, form z = c*c, seed the sum.
    logic [FRAC_BITS-1:0]   w_c;
    logic [2*FRAC_BITS-1:0] w_csq;
    t_hor_word              r_z_word;
    t_hor_word              n_z_word;

    assign w_c   = w_div[DIV_STAGES].quo[QUO_W-1 -: FRAC_BITS];
    assign w_csq = w_c * w_c;

    always_comb begin
        n_z_word.c       = w_c;
        n_z_word.z       = w_csq[2*FRAC_BITS-1:FRAC_BITS];
        n_z_word.s       = S_INIT;
        n_z_word.invalid = w_div[DIV_STAGES].invalid;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[Z_IDX]) begin
            r_z_word <= n_z_word;
        end
    end

    // Horner chain, coefficients from 1/(2K-3) down to 1.
    t_hor_word w_hor [NUM_TERMS];

    assign w_hor[0] = r_z_word;

    for (genvar g = 0; g < NUM_TERMS - 1; g++) begin : g_hor
        localparam int KK = NUM_TERMS - 1 - g;
        localparam logic [S_W-1:0] RECIP = S_W'((64'd1 << FRAC_BITS) / (2 * KK - 1));

        lnat_horner_stage u_hor (
            .i_clk   (i_clk),
            .i_load  (w_rdy[Z_IDX+1+g]),
            .i_recip (RECIP),
            .i_word  (w_hor[g]),
            .o_word  (w_hor[g+1])
        );
    end

    // Output stage: y = c*s, double it, saturate, force zero on a bad argument.
    logic [FRAC_BITS+S_W-1:0] w_y_prod;
    logic [R_W-1:0]           w_dbl;
    logic [RES_W-1:0]         r_result;
    logic [RES_W-1:0]         n_result;
    logic                     r_invalid;

    assign w_y_prod = w_hor[NUM_TERMS-1].c * w_hor[NUM_TERMS-1].s;
    assign w_dbl    = {w_y_prod[FRAC_BITS+S_W-1:FRAC_BITS], 1'b0};

    always_comb begin
        if (w_hor[NUM_TERMS-1].invalid) begin
            n_result = '0;
        end else if (CMP_W'(w_dbl) > CMP_W'(RES_MAX)) begin
            n_result = RES_MAX;
        end else begin
            n_result = RES_W'(w_dbl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[OUT_IDX]) begin
            r_result  <= n_result;
            r_invalid <= w_hor[NUM_TERMS-1].invalid;
        end
    end

    assign o_log_result  = r_result;
    assign o_invalid_arg = r_invalid;

endmodule

>>> tb/lnat_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the ln atanh-series unit: watches both word channels,
// predicts each result and compares it field by field. Depends on lnat_pkg.
module lnat_result_checker
    import lnat_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [N_W-1:0]   i_n_value,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  logic [RES_W-1:0] i_log_result,
    input  logic             i_invalid_arg,
    output int               o_fail_count,
    output int               o_outstanding
);

    typedef struct packed {
        logic [RES_W-1:0] log_val;
        logic             bad_arg;
    } t_log_word;

    t_log_word expected_logs[$];
    int        fail_total = 0;

    assign o_fail_count = fail_total;

    initial o_outstanding = 0;

    // Fixed-point product, truncated
    function automatic logic [63:0] fx_scale(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b);
        return 64'(p >> FRAC_BITS);
    endfunction

    function automatic t_log_word ln_series_estimate(input logic [N_W-1:0] n);
        logic [63:0] c;
        logic [63:0] z;
        logic [63:0] s;
        logic [63:0] y;
        logic [63:0] r;
        t_log_word   w;
        if (n == '0) begin
            w.log_val = '0;
            w.bad_arg = 1'b1;
            return w;
        end
        c = ((64'(n) - 64'd1) << FRAC_BITS) / (64'(n) + 64'd1);
        z = fx_scale(c, c);
        s = (64'd1 << FRAC_BITS) / 64'(2 * NUM_TERMS - 1);
        for (int k = NUM_TERMS - 1; k >= 1; k--)
            s = (64'd1 << FRAC_BITS) / 64'(2 * k - 1) + fx_scale(z, s);
        y = fx_scale(c, s);
        r = y << 1;
        if (r > 64'(RES_MAX))
            r = 64'(RES_MAX);
        w.log_val = r[RES_W-1:0];
        w.bad_arg = 1'b0;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        t_log_word want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                expected_logs.push_back(ln_series_estimate(i_n_value));
            if (i_out_valid && i_out_ready) begin
                if (expected_logs.size() == 0) begin
                    $display("%0t: result word with nothing expected", $realtime);
                    fail_total++;
                end else begin
                    want = expected_logs.pop_front();
                    if (i_log_result !== want.log_val)
                        report_mismatch("log_result", i_log_result, want.log_val);
                    if (i_invalid_arg !== want.bad_arg)
                        report_mismatch("invalid_arg", i_invalid_arg, want.bad_arg);
                end
            end
        end
        o_outstanding <= expected_logs.size();
    end

endmodule

>>> tb/ln_atanh_series_unit_tb.sv
`timescale 1ns / 100ps
// Top of the ln atanh-series unit testbench: clock, reset, argument words and
// result back-pressure. Depends on lnat_pkg, ln_atanh_series_unit, lnat_result_checker.
module ln_atanh_series_unit_tb
    import lnat_pkg::*;
();

    localparam int CYCLE_LIMIT  = 400000;  // far beyond the slowest correct run
    localparam int DRAIN_CYCLES = 40;      // pipeline is 15 stages deep
    localparam int RANDOM_WORDS = 600;     // per phase

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic             i_ready = 1'b0;
    logic [N_W-1:0]   i_n_value = '0;
    logic             o_ready;
    logic             o_valid;
    logic [RES_W-1:0] o_log_result;
    logic             o_invalid_arg;

    int fail_count;
    int outstanding;
    int snd_idle_pct = 0;   // chance in a hundred that the sender holds off a cycle
    int rcv_idle_pct = 0;   // chance in a hundred that the receiver stalls a cycle
    int cycle_count = 0;

    ln_atanh_series_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_n_value     (i_n_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_log_result  (o_log_result),
        .o_invalid_arg (o_invalid_arg)
    );

    lnat_result_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_n_value     (i_n_value),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_log_result  (o_log_result),
        .i_invalid_arg (o_invalid_arg),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Receiver back-pressure: draw afresh every cycle
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    // Watchdog: end the run if the pipeline hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("ln_atanh_series_unit_tb NOT OK");
            $finish;
        end
    end

    // Offer one argument word; return on the edge that accepts it. Exactly one
    // assignment to i_valid per edge, so a back-to-back word keeps valid high.
    task automatic send_argument(input logic [N_W-1:0] n);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_valid   <= 1'b0;
            i_n_value <= N_W'($urandom);   // junk while idle
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_n_value <= n;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Random argument shaped to hit small, sparse and top-end values as well
    // as the full range; zero stays in the mix for the invalid flag.
    function automatic logic [N_W-1:0] pick_argument();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return N_W'($urandom);
        else if (sel < 65)
            return N_W'($urandom_range(31));
        else if (sel < 80)
            return N_W'(1) << $urandom_range(N_W - 1);
        else if (sel < 90)
            return N_W'(16'hFFFF - $urandom_range(255));
        else
            return N_W'($urandom_range(1));
    endfunction

    initial begin
        logic [N_W-1:0] corner_args[$];
        corner_args = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd10, 16'd100, 16'd1000,
                        16'h00FF, 16'h0100, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000,
                        16'hFF00, 16'hFFFE, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF};

        // Hold reset, then release it for good
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    snd_idle_pct = 21;
                    rcv_idle_pct = 85;
                end
                1: begin
                    snd_idle_pct = 85;
                    rcv_idle_pct = 21;
                end
                default: begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            // Corner arguments first: zero, one, the extremes and bit patterns
            if (phase == 0) begin
                foreach (corner_args[i])
                    send_argument(corner_args[i]);
            end
            for (int i = 0; i < RANDOM_WORDS; i++)
                send_argument(pick_argument());
        end
        i_valid <= 1'b0;

        // Drain: wait for every expected word, then a little longer to catch strays
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("ln_atanh_series_unit_tb OK");
        else
            $display("ln_atanh_series_unit_tb NOT OK");
        $finish;
    end

endmodule
